### rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with no reset qualification.
`define EESEQ_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Clocked assertion switched off while the active-low reset is applied.
`define EESEQ_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`endif

### rtl/eeseq_pkg.sv
// Shared types and constants for the SPI EEPROM transfer sequencer.
`timescale 1ns / 1ps
package eeseq_pkg;

    localparam int PAGE_BYTES      = 64;     // power of two
    localparam int MEMORY_BYTES    = 32768;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ADDR_W  = 16;
    localparam int CNT_W   = 16;
    localparam int PG_W    = $clog2(PAGE_BYTES + 1);
    localparam int OFS_W   = $clog2(PAGE_BYTES);
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [7:0] STATUS_OPCODE = 8'h05;
    localparam logic [7:0] POLL_DUMMY    = 8'hFF;
    localparam int         BUSY_BIT      = 0;

    localparam logic [7:0] RESET_READ_OP  = 8'h03;
    localparam logic [7:0] RESET_WRITE_OP = 8'h02;
    localparam logic [7:0] RESET_WEN_OP   = 8'h06;

    typedef enum logic [1:0] {
        ACT_START_READ  = 2'd0,
        ACT_START_WRITE = 2'd1,
        ACT_BYTE_DONE   = 2'd2,
        ACT_NONE        = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_READ_OP  = 2'd0,
        CFG_WRITE_OP = 2'd1,
        CFG_WEN_OP   = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_START_RD = 2'd0,
        KIND_START_WR = 2'd1,
        KIND_BYTE     = 2'd2
    } kind_t;

    // classified transaction held in the queue
    typedef struct packed {
        kind_t              kind;
        logic               no_bus;   // start that ends at once (error or empty)
        logic [ADDR_W-1:0]  start_address;
        logic [CNT_W-1:0]   byte_count;
        logic [7:0]         received_byte;
        logic [7:0]         write_data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // result word, send_valid in bit 0
    typedef struct packed {
        logic [1:0] pad;
        logic       error;
        logic       done_res;
        logic       data_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       select_active;
        logic [7:0] send_byte;
        logic       send_valid;
    } out_t;

endpackage

### rtl/eeseq_front.sv
// Front end: classifies transactions, queues all but ACT_NONE for the sequencer.
`timescale 1ns / 1ps
module eeseq_front #(
    parameter int QUEUE_DEPTH = eeseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [eeseq_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                         s_tuser,
    output eeseq_pkg::head_t                   head,
    input  logic                               pop
);
    import eeseq_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic              push;
    logic              keep;
    item_t             cls;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W:0]   end_addr;
    logic              do_pop;

    assign addr     = s_tdata[ADDR_W-1:0];
    assign cnt      = s_tdata[ADDR_W+CNT_W-1:ADDR_W];
    assign end_addr = {1'b0, addr} + {1'b0, cnt};

    always_comb begin
        cls.start_address = addr;
        cls.byte_count    = cnt;
        cls.received_byte = s_tdata[ADDR_W+CNT_W+7:ADDR_W+CNT_W];
        cls.write_data    = s_tdata[ADDR_W+CNT_W+15:ADDR_W+CNT_W+8];
        cls.kind          = KIND_BYTE;
        cls.no_bus        = 1'b0;
        keep              = 1'b1;
        unique case (action_t'(s_tuser))
            ACT_START_READ: begin
                cls.kind   = KIND_START_RD;
                cls.no_bus = (cnt == '0);
            end
            ACT_START_WRITE: begin
                cls.kind   = KIND_START_WR;
                cls.no_bus = (end_addr > (ADDR_W+1)'(MEMORY_BYTES)) || (cnt == '0);
            end
            ACT_BYTE_DONE: cls.kind = KIND_BYTE;
            default: keep = 1'b0;
        endcase
    end

    assign s_tready   = (count_reg != COUNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready && keep;
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/eeseq_back.sv
// Back end: transfer sequencer state machine, configuration registers and output register.
`timescale 1ns / 1ps
module eeseq_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  eeseq_pkg::head_t               head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [eeseq_pkg::M_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [7:0]                     cfg_data
);
    import eeseq_pkg::*;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_POLL_RD  = 10'b00_0000_0010,
        PH_POLL_WEN = 10'b00_0000_0100,
        PH_WEN      = 10'b00_0000_1000,
        PH_POLL_WR  = 10'b00_0001_0000,
        PH_OPCODE   = 10'b00_0010_0000,
        PH_ADDR_HI  = 10'b00_0100_0000,
        PH_ADDR_LO  = 10'b00_1000_0000,
        PH_RD_DATA  = 10'b01_0000_0000,
        PH_WR_DATA  = 10'b10_0000_0000
    } phase_t;

    function automatic out_t sending(input logic [7:0] b);
        out_t r;
        r               = '0;
        r.send_valid    = 1'b1;
        r.send_byte     = b;
        r.select_active = 1'b1;
        return r;
    endfunction

    function automatic logic [PG_W-1:0] page_len(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0] rem);
        logic [PG_W-1:0] pg;
        pg = PG_W'(PAGE_BYTES) - PG_W'(a[OFS_W-1:0]);
        if (CNT_W'(pg) > rem) begin
            pg = PG_W'(rem);
        end
        return pg;
    endfunction

    phase_t            phase_reg, phase_next;
    logic              is_write_reg, is_write_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [PG_W-1:0]   page_reg, page_next;
    logic              skip_reg, skip_next;
    logic              sub_reg, sub_next;
    logic [7:0]        read_op_reg, write_op_reg, wen_op_reg;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg;
    logic              m_last_reg;

    logic [1:0]        n_res;
    out_t              r0, r1;
    logic              wstep;
    logic              out_free;
    logic              load_out;
    logic              use_r1;
    logic              commit;
    logic [CNT_W-1:0]  rem_dec;
    item_t             it;

    assign it       = head.item;
    assign rem_dec  = rem_reg - 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    // result words and next state for the transaction at the queue head
    always_comb begin
        n_res         = 2'd0;
        r0            = '0;
        r1            = '0;
        wstep         = 1'b0;
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        page_next     = page_reg;
        skip_next     = skip_reg;
        if (it.kind == KIND_START_RD || it.kind == KIND_START_WR) begin
            if (phase_reg == PH_IDLE) begin
                addr_next     = it.start_address;
                rem_next      = it.byte_count;
                is_write_next = (it.kind == KIND_START_WR);
                n_res         = 2'd1;
                if (it.no_bus) begin
                    r0.done_res = 1'b1;
                    r0.error    = (it.kind == KIND_START_WR);
                end else begin
                    r0        = sending(STATUS_OPCODE);
                    skip_next = 1'b1;
                    if (it.kind == KIND_START_WR) begin
                        page_next  = page_len(it.start_address, it.byte_count);
                        phase_next = PH_POLL_WEN;
                    end else begin
                        phase_next = PH_POLL_RD;
                    end
                end
            end
        end else begin
            unique case (phase_reg) inside
                PH_IDLE: n_res = 2'd0;
                PH_POLL_RD, PH_POLL_WEN, PH_POLL_WR: begin
                    if (skip_reg || it.received_byte[BUSY_BIT]) begin
                        skip_next = 1'b0;
                        n_res     = 2'd1;
                        r0        = sending(POLL_DUMMY);
                    end else begin
                        n_res = 2'd2;
                        if (phase_reg == PH_POLL_RD) begin
                            r1         = sending(read_op_reg);
                            phase_next = PH_OPCODE;
                        end else if (phase_reg == PH_POLL_WEN) begin
                            r1         = sending(wen_op_reg);
                            phase_next = PH_WEN;
                        end else begin
                            r1         = sending(write_op_reg);
                            phase_next = PH_OPCODE;
                        end
                    end
                end
                PH_WEN: begin
                    n_res      = 2'd2;
                    r1         = sending(STATUS_OPCODE);
                    skip_next  = 1'b1;
                    phase_next = PH_POLL_WR;
                end
                PH_OPCODE: begin
                    n_res      = 2'd1;
                    r0         = sending(addr_reg[15:8]);
                    phase_next = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_res      = 2'd1;
                    r0         = sending(addr_reg[7:0]);
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    if (is_write_reg) begin
                        wstep = 1'b1;
                    end else begin
                        n_res      = 2'd1;
                        r0         = sending(8'h00);
                        phase_next = PH_RD_DATA;
                    end
                end
                PH_RD_DATA: begin
                    n_res     = 2'd1;
                    rem_next  = rem_dec;
                    addr_next = addr_reg + 1'b1;
                    if (rem_dec != '0) begin
                        r0 = sending(8'h00);
                    end else begin
                        r0.done_res = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    r0.read_valid = 1'b1;
                    r0.read_byte  = it.received_byte;
                end
                PH_WR_DATA: wstep = 1'b1;
                default: phase_next = PH_IDLE;
            endcase
            if (wstep) begin
                if (page_reg != '0) begin
                    n_res         = 2'd1;
                    r0            = sending(it.write_data);
                    r0.data_taken = 1'b1;
                    page_next     = page_reg - 1'b1;
                    rem_next      = rem_dec;
                    addr_next     = addr_reg + 1'b1;
                    phase_next    = PH_WR_DATA;
                end else if (rem_reg == '0) begin
                    n_res       = 2'd1;
                    r0.done_res = 1'b1;
                    phase_next  = PH_IDLE;
                end else begin
                    n_res      = 2'd2;
                    r1         = sending(STATUS_OPCODE);
                    page_next  = page_len(addr_reg, rem_reg);
                    skip_next  = 1'b1;
                    phase_next = PH_POLL_WEN;
                end
            end
        end
    end

    // issue: one result word per cycle while the output register is free, state committed with the last one
    always_comb begin
        pop      = 1'b0;
        commit   = 1'b0;
        load_out = 1'b0;
        use_r1   = 1'b0;
        sub_next = sub_reg;
        if (head.valid) begin
            unique case (n_res)
                2'd0: begin
                    pop    = 1'b1;
                    commit = 1'b1;
                end
                2'd1: begin
                    if (out_free) begin
                        load_out = 1'b1;
                        pop      = 1'b1;
                        commit   = 1'b1;
                    end
                end
                2'd2: begin
                    if (out_free) begin
                        load_out = 1'b1;
                        if (sub_reg) begin
                            use_r1   = 1'b1;
                            pop      = 1'b1;
                            commit   = 1'b1;
                            sub_next = 1'b0;
                        end else begin
                            sub_next = 1'b1;
                        end
                    end
                end
                default: begin
                    pop    = 1'b1;
                    commit = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            skip_reg     <= 1'b0;
            sub_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            read_op_reg  <= RESET_READ_OP;
            write_op_reg <= RESET_WRITE_OP;
            wen_op_reg   <= RESET_WEN_OP;
        end else begin
            sub_reg     <= sub_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
            end
            if (cfg_valid) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_READ_OP:  read_op_reg  <= cfg_data;
                    CFG_WRITE_OP: write_op_reg <= cfg_data;
                    CFG_WEN_OP:   wen_op_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            is_write_reg <= is_write_next;
            addr_reg     <= addr_next;
            rem_reg      <= rem_next;
            page_reg     <= page_next;
        end
        if (load_out) begin
            m_data_reg <= use_r1 ? r1 : r0;
            m_last_reg <= use_r1 || (n_res == 2'd1);
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

endmodule

### rtl/spi_eeprom_transfer_sequencer.sv
// Top level of the SPI EEPROM transfer sequencer.
// A transaction is registered in the input queue, its result in the output register.
// Throughput: one result word per cycle while the output register is free; a transaction
// that yields two results holds the sequencer until both are issued; the queue keeps
// taking transactions until full. Transactions that yield no result leave the queue.
// Reset (aresetn low, synchronous): queue emptied, sequencer idle, opcodes back to 3, 2, 6.
`timescale 1ns / 1ps
module spi_eeprom_transfer_sequencer #(
    parameter int QUEUE_DEPTH = eeseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_address[15:0], byte_count[31:16], received_byte[39:32], write_data[47:40]
    input  logic [eeseq_pkg::S_DATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // send_valid[0], send_byte[8:1], select_active[9], read_valid[10], read_byte[18:11],
    // data_taken[19], done_res[20], error[21], zero[23:22]
    output logic [eeseq_pkg::M_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [7:0]                     cfg_data
);
    import eeseq_pkg::*;

    head_t head;
    logic  pop;

    eeseq_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    eeseq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### rtl/eeseq_checker.sv
// Port-level checker for the SPI EEPROM transfer sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eeseq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [eeseq_pkg::M_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import eeseq_pkg::*;

    out_t o;
    assign o = m_tdata;

    `EESEQ_ASSERT(a_reset_idle, aclk, !aresetn |=> !m_tvalid)
    `EESEQ_ASSERT_RST(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `EESEQ_ASSERT_RST(a_error_ends, aclk, aresetn, m_tvalid && o.error |-> o.done_res && m_tlast)
    `EESEQ_ASSERT_RST(a_done_quiet, aclk, aresetn, m_tvalid && o.done_res |-> !o.send_valid && !o.select_active && m_tlast)
    `EESEQ_ASSERT_RST(a_send_selects, aclk, aresetn, m_tvalid && o.send_valid |-> o.select_active && !o.done_res)

endmodule

bind spi_eeprom_transfer_sequencer eeseq_checker u_eeseq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### verif/tb_spi_eeprom_transfer_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SPI EEPROM transfer sequencer, with an in-bench model of the sequencer.
module tb_spi_eeprom_transfer_sequencer;
    import eeseq_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASE_ITEMS     = 500;
    localparam int MAX_REPORTS     = 40;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_POLL_RD, SQ_POLL_WEN, SQ_WEN, SQ_POLL_WR,
        SQ_OPCODE, SQ_ADDR_HI, SQ_ADDR_LO, SQ_RD_DATA, SQ_WR_DATA
    } seq_phase_t;

    typedef struct packed {
        out_t word;
        logic last;
    } bus_word_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [1:0]          s_tuser   = 2'b00;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [1:0]          cfg_index = 2'b00;
    logic [7:0]          cfg_data  = 8'h00;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_ready;

    // sequencer model state
    seq_phase_t sq_phase     = SQ_IDLE;
    logic       sq_writing   = 1'b0;
    logic [15:0] sq_addr     = '0;
    logic [15:0] sq_left     = '0;
    logic [8:0] sq_page_left = '0;
    logic       sq_skip_echo = 1'b0;
    logic [7:0] op_read      = RESET_READ_OP;
    logic [7:0] op_write     = RESET_WRITE_OP;
    logic [7:0] op_wen       = RESET_WEN_OP;

    bus_word_t pending_words[$];

    int mismatches    = 0;
    int words_checked = 0;
    int useful_items  = 0;
    int transfers     = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 54;

    spi_eeprom_transfer_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic out_t shift_out(input logic [7:0] b);
        out_t w;
        w = '0;
        w.send_valid    = 1'b1;
        w.send_byte     = b;
        w.select_active = 1'b1;
        return w;
    endfunction

    task automatic queue_word(input out_t w, input logic last);
        bus_word_t e;
        e.word = w;
        e.last = last;
        pending_words.push_back(e);
    endtask

    task automatic open_poll(input seq_phase_t nxt);
        sq_phase     = nxt;
        sq_skip_echo = 1'b1;
        queue_word(shift_out(STATUS_OPCODE), 1'b1);
    endtask

    task automatic size_page();
        int room;
        room = PAGE_BYTES - (int'(sq_addr) % PAGE_BYTES);
        if (room > int'(sq_left))
            room = int'(sq_left);
        sq_page_left = 9'(room);
    endtask

    task automatic next_write_byte(input logic [7:0] wd);
        out_t w;
        w = '0;
        if (sq_page_left != 0) begin
            w = shift_out(wd);
            w.data_taken = 1'b1;
            sq_page_left = sq_page_left - 1;
            sq_left      = sq_left - 1;
            sq_addr      = sq_addr + 1;
            sq_phase     = SQ_WR_DATA;
            queue_word(w, 1'b1);
        end else if (sq_left == 0) begin
            w.done_res = 1'b1;
            sq_phase   = SQ_IDLE;
            queue_word(w, 1'b1);
        end else begin
            // page finished, next page needs its own enable
            queue_word(w, 1'b0);
            size_page();
            open_poll(SQ_POLL_WEN);
        end
    endtask

    task automatic predict_sequencer(input action_t act, input logic [15:0] addr,
                                     input logic [15:0] cnt, input logic [7:0] rx,
                                     input logic [7:0] wd);
        out_t w;
        w = '0;
        if (act == ACT_START_READ || act == ACT_START_WRITE) begin
            if (sq_phase == SQ_IDLE) begin
                sq_addr    = addr;
                sq_left    = cnt;
                sq_writing = (act == ACT_START_WRITE);
                if (sq_writing) begin
                    if ({1'b0, addr} + {1'b0, cnt} > 17'(MEMORY_BYTES) || cnt == 0) begin
                        w.done_res = 1'b1;
                        w.error    = 1'b1;
                        queue_word(w, 1'b1);
                    end else begin
                        size_page();
                        open_poll(SQ_POLL_WEN);
                    end
                end else if (cnt == 0) begin
                    w.done_res = 1'b1;
                    queue_word(w, 1'b1);
                end else begin
                    open_poll(SQ_POLL_RD);
                end
            end
        end else if (act == ACT_BYTE_DONE) begin
            case (sq_phase)
                SQ_IDLE: ;
                SQ_POLL_RD, SQ_POLL_WEN, SQ_POLL_WR: begin
                    if (sq_skip_echo || rx[BUSY_BIT]) begin
                        sq_skip_echo = 1'b0;
                        queue_word(shift_out(POLL_DUMMY), 1'b1);
                    end else begin
                        queue_word(w, 1'b0);
                        if (sq_phase == SQ_POLL_RD) begin
                            queue_word(shift_out(op_read), 1'b1);
                            sq_phase = SQ_OPCODE;
                        end else if (sq_phase == SQ_POLL_WEN) begin
                            queue_word(shift_out(op_wen), 1'b1);
                            sq_phase = SQ_WEN;
                        end else begin
                            queue_word(shift_out(op_write), 1'b1);
                            sq_phase = SQ_OPCODE;
                        end
                    end
                end
                SQ_WEN: begin
                    queue_word(w, 1'b0);
                    open_poll(SQ_POLL_WR);
                end
                SQ_OPCODE: begin
                    sq_phase = SQ_ADDR_HI;
                    queue_word(shift_out(sq_addr[15:8]), 1'b1);
                end
                SQ_ADDR_HI: begin
                    sq_phase = SQ_ADDR_LO;
                    queue_word(shift_out(sq_addr[7:0]), 1'b1);
                end
                SQ_ADDR_LO: begin
                    if (sq_writing) begin
                        next_write_byte(wd);
                    end else begin
                        sq_phase = SQ_RD_DATA;
                        queue_word(shift_out(8'h00), 1'b1);
                    end
                end
                SQ_RD_DATA: begin
                    sq_left = sq_left - 1;
                    sq_addr = sq_addr + 1;
                    if (sq_left != 0) begin
                        w = shift_out(8'h00);
                    end else begin
                        w.done_res = 1'b1;
                        sq_phase   = SQ_IDLE;
                    end
                    w.read_valid = 1'b1;
                    w.read_byte  = rx;
                    queue_word(w, 1'b1);
                end
                SQ_WR_DATA: next_write_byte(wd);
                default: sq_phase = SQ_IDLE;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        bus_word_t want;
        out_t      got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = out_t'(m_tdata);
                words_checked++;
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: result expected none, got %h last %b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = pending_words.pop_front();
                    check_field("send_valid", want.word.send_valid, got.send_valid);
                    check_field("send_byte", want.word.send_byte, got.send_byte);
                    check_field("select_active", want.word.select_active, got.select_active);
                    check_field("read_valid", want.word.read_valid, got.read_valid);
                    check_field("read_byte", want.word.read_byte, got.read_byte);
                    check_field("data_taken", want.word.data_taken, got.data_taken);
                    check_field("done_res", want.word.done_res, got.done_res);
                    check_field("error", want.word.error, got.error);
                    check_field("pad", want.word.pad, got.pad);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                predict_sequencer(action_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                                  s_tdata[39:32], s_tdata[47:40]);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_READ_OP:  op_read  = cfg_data;
                    CFG_WRITE_OP: op_write = cfg_data;
                    CFG_WEN_OP:   op_wen   = cfg_data;
                    default: ;
                endcase
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("FAIL");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input action_t act, input logic [15:0] addr,
                             input logic [15:0] cnt, input logic [7:0] rx,
                             input logic [7:0] wd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {wd, rx, cnt, addr};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_opcode(input cfg_index_t idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic finish_transfer(input int noise_pct);
        logic [7:0] rx;
        action_t    junk;
        while (sq_phase != SQ_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                junk = action_t'($urandom_range(3));
                if (junk == ACT_BYTE_DONE)
                    junk = ACT_NONE;
                send_item(junk, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end
            rx = 8'($urandom);
            if (sq_phase inside {SQ_POLL_RD, SQ_POLL_WEN, SQ_POLL_WR} && $urandom_range(1))
                rx[BUSY_BIT] = 1'b0;
            send_item(ACT_BYTE_DONE, 16'($urandom), 16'($urandom), rx, 8'($urandom));
            useful_items++;
        end
    endtask

    task automatic run_transfer(input action_t act, input logic [15:0] addr,
                                input logic [15:0] cnt, input int noise_pct);
        transfers++;
        useful_items++;
        send_item(act, addr, cnt, 8'($urandom), 8'($urandom));
        finish_transfer(noise_pct);
    endtask

    task automatic test_immediate_ends();
        run_transfer(ACT_START_READ, 16'hFFFF, 16'h0000, 0);
        run_transfer(ACT_START_WRITE, 16'h0000, 16'h0000, 0);
        run_transfer(ACT_START_WRITE, 16'h7FFF, 16'h0002, 0);
        run_transfer(ACT_START_WRITE, 16'hFFFF, 16'hFFFF, 0);
    endtask

    task automatic test_ignored_items();
        send_item(ACT_BYTE_DONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        transfers++;
        useful_items++;
        // read that wraps past the top of the address space
        send_item(ACT_START_READ, 16'hFFFF, 16'h0002, 8'h00, 8'h00);
        send_item(ACT_START_WRITE, 16'h0000, 16'h0001, 8'h00, 8'h00);
        send_item(ACT_START_READ, 16'h1234, 16'h0005, 8'h00, 8'h00);
        send_item(ACT_NONE, 16'h0000, 16'h0000, 8'h00, 8'h00);
        finish_transfer(0);
    endtask

    task automatic test_memory_end_write();
        run_transfer(ACT_START_WRITE, 16'h7FFE, 16'h0002, 0);
    endtask

    task automatic test_opcode_settings();
        logic [7:0] v;
        for (int pass = 0; pass < 4; pass++) begin
            v = (pass == 0) ? 8'h00 : (pass == 1) ? 8'hFF : 8'($urandom);
            settle();
            set_opcode(CFG_READ_OP, v);
            set_opcode(CFG_WRITE_OP, ~v);
            set_opcode(CFG_WEN_OP, v ^ 8'h5A);
            set_opcode(CFG_UNUSED, 8'($urandom));
            run_transfer(ACT_START_READ, 16'h0000, 16'h0001, 0);
            run_transfer(ACT_START_WRITE, 16'h003F, 16'h0002, 0);
        end
        settle();
        set_opcode(CFG_READ_OP, RESET_READ_OP);
        set_opcode(CFG_WRITE_OP, RESET_WRITE_OP);
        set_opcode(CFG_WEN_OP, RESET_WEN_OP);
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle);
        int          target;
        int          pick;
        int          since_cfg;
        logic [15:0] addr;
        logic [15:0] cnt;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        target    = useful_items + PHASE_ITEMS;
        since_cfg = 0;
        while (useful_items < target) begin
            if (since_cfg == 40) begin
                settle();
                repeat ($urandom_range(3, 1))
                    set_opcode(cfg_index_t'($urandom_range(3)), 8'($urandom));
                since_cfg = 0;
            end
            since_cfg++;
            cnt  = ($urandom_range(4) == 0) ? 16'($urandom_range(150, 1))
                                            : 16'($urandom_range(6, 1));
            pick = $urandom_range(99);
            if (pick < 40) begin
                run_transfer(ACT_START_READ, 16'($urandom), cnt, 5);
            end else if (pick < 80) begin
                addr = 16'($urandom_range(MEMORY_BYTES - int'(cnt)));
                if ($urandom_range(3) == 0)
                    addr = {addr[15:6], 6'($urandom_range(63, 56))};
                if ({1'b0, addr} + {1'b0, cnt} > 17'(MEMORY_BYTES))
                    addr = 16'(MEMORY_BYTES - int'(cnt));
                run_transfer(ACT_START_WRITE, addr, cnt, 5);
            end else if (pick < 88) begin
                case ($urandom_range(2))
                    0: begin
                        addr = 16'($urandom_range(65535, MEMORY_BYTES));
                        cnt  = 16'($urandom);
                    end
                    1: begin
                        addr = 16'($urandom_range(MEMORY_BYTES - 1));
                        cnt  = 16'(MEMORY_BYTES + 1 - int'(addr) + $urandom_range(200));
                    end
                    default: begin
                        addr = 16'($urandom);
                        cnt  = 16'h0000;
                    end
                endcase
                run_transfer(ACT_START_WRITE, addr, cnt, 5);
            end else if (pick < 94) begin
                run_transfer(ACT_START_READ, 16'($urandom), 16'h0000, 5);
            end else begin
                send_item($urandom_range(1) ? ACT_BYTE_DONE : ACT_NONE, 16'($urandom),
                          16'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_immediate_ends();
        test_ignored_items();
        test_memory_end_write();
        test_opcode_settings();
        test_random_traffic(33, 54);
        test_random_traffic(54, 33);
        test_random_traffic(0, 0);
        settle();

        $display("Ran %0d transfers over %0d items; %0d result words checked.",
                 transfers, useful_items, words_checked);
        $display("Covered reads, page-split writes, range errors, ignored items, opcode changes.");
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### spi_eeprom_transfer_sequencer.f
+incdir+rtl
rtl/eeseq_pkg.sv
rtl/eeseq_front.sv
rtl/eeseq_back.sv
rtl/spi_eeprom_transfer_sequencer.sv
rtl/eeseq_checker.sv
verif/tb_spi_eeprom_transfer_sequencer.sv
